@@ hdl/exspr_pkg.sv @@
// ----------------------------------------------------------------------------
// exspr_pkg
// Types, register numbers, status-register bits and vector constants of the
// exception entry and special-purpose register unit.
// ----------------------------------------------------------------------------
package exspr_pkg;

  typedef enum logic [1:0] {
    OP_READ   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_EXCEPT = 2'd2,
    OP_RESET  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_ENTERED   = 2'd1,
    ST_MASKED    = 2'd2,
    ST_UNHANDLED = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CAUSE_ARCH    = 3'd0,
    CAUSE_BUS     = 3'd1,
    CAUSE_INT     = 3'd2,
    CAUSE_ILLEGAL = 3'd3,
    CAUSE_ILLJUMP = 3'd4,
    CAUSE_RSTVEC  = 3'd5,
    CAUSE_FOREIGN = 3'd6
  } cause_t;

  // configuration register indexes
  localparam logic CFG_OVERRIDE = 1'b0;
  localparam logic CFG_START    = 1'b1;

  // status-register bit positions
  localparam int SR_SM  = 0;
  localparam int SR_TEE = 1;
  localparam int SR_IEE = 2;
  localparam int SR_EPH = 14;
  localparam int SR_FO  = 15;

  localparam logic [31:0] SR_RESET      = 32'h0000_8001;
  localparam logic [31:0] SR_ENTRY_CLR  = 32'h0000_0066;  // DME, IME, IEE, TEE
  localparam logic [31:0] TTMR_IP       = 32'h1000_0000;

  // register numbers
  localparam logic [15:0] IDX_EVBAR = 16'd11;
  localparam logic [15:0] IDX_NPC   = 16'd16;
  localparam logic [15:0] IDX_SR    = 16'd17;
  localparam logic [15:0] IDX_PPC   = 16'd18;
  localparam logic [15:0] IDX_EPCR  = 16'd32;
  localparam logic [15:0] IDX_ESR   = 16'd64;
  localparam logic [15:0] IDX_TTMR  = 16'h5000;

  // vectors
  localparam logic [15:0] VEC_BUS     = 16'h0200;
  localparam logic [15:0] VEC_TIMER   = 16'h0500;
  localparam logic [15:0] VEC_ILLEGAL = 16'h0700;
  localparam logic [15:0] VEC_INT     = 16'h0800;
  localparam logic [31:0] VEC_LIMIT   = 32'h0000_0F00;
  localparam logic [31:0] VEC_MASK    = 32'h0000_FF00;
  localparam logic [31:0] VEC_HIGH    = 32'hF000_0000;
  localparam logic [31:0] VEC_RESET   = 32'h0000_0100;

  localparam logic [31:0] START_RESET = 32'h0000_0100;

  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 72;

  // input item, reg_id in the lowest bits
  typedef struct packed {
    logic [31:0] current_pc;
    logic [15:0] vector_offset;
    logic [2:0]  cause;
    logic [31:0] write_value;
    logic [15:0] reg_id;
  } in_item_t;

  // result item, read_data in the lowest bits
  typedef struct packed {
    status_t     status;
    logic        pc_changed;
    logic [31:0] next_pc;
    logic [31:0] read_data;
  } out_item_t;

  // base vector of a cause that goes through the range and mask checks
  function automatic logic [15:0] base_vector(input cause_t cause,
                                              input logic [15:0] offset);
    logic [15:0] v;
    case (cause)
      CAUSE_ARCH:    v = offset;
      CAUSE_BUS:     v = VEC_BUS;
      CAUSE_INT:     v = VEC_INT;
      CAUSE_ILLEGAL: v = VEC_ILLEGAL;
      default:       v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

@@ hdl/exspr_ram.sv @@
// ----------------------------------------------------------------------------
// exspr_ram
// Register store: one write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module exspr_ram #(
  parameter int ADDR_BITS = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [31:0]          wdata,
  input  logic                 re,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [31:0]          rdata
);

  localparam int DEPTH = 2 ** ADDR_BITS;

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/exception_entry_and_spr_unit_top.sv @@
// ----------------------------------------------------------------------------
// exception_entry_and_spr_unit_top
// Special-purpose register store and exception entry of a 32-bit core.
//
//   channel   dir  handshake          payload
//   s_*       in   s_tvalid/s_tready  s_tuser: op; s_tdata: request fields
//   m_*       out  m_tvalid/m_tready  m_tdata: result fields
//   cfg_*     in   cfg_we             cfg_index, cfg_data
//
// A read, a write, a masked or handed-back exception and a core reset go
// through accept, store lookup and result steps; a taken exception adds an
// ESR write step, since EPCR and ESR share the single store write port.
// Reset and the core reset request sweep the store one word a cycle, with
// s_tready low throughout the sweep.
// A result waits in the output register; a new request is accepted meanwhile
// and stalls at the result step only while that register is still full.
// ----------------------------------------------------------------------------
module exception_entry_and_spr_unit_top #(
  parameter int SPR_ADDR_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // reg_id, write_value, cause, vector_offset, current_pc, zero pad
  input  logic [exspr_pkg::IN_TDATA_W-1:0]   s_tdata,
  // op
  input  logic [1:0]                         s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // read_data, next_pc, pc_changed, status, zero pad
  output logic [exspr_pkg::OUT_TDATA_W-1:0]  m_tdata,
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [31:0]                        cfg_data
);

  localparam logic [SPR_ADDR_BITS-1:0] LAST_ADDR = '1;
  localparam logic [SPR_ADDR_BITS-1:0] A_EVBAR = SPR_ADDR_BITS'(exspr_pkg::IDX_EVBAR);
  localparam logic [SPR_ADDR_BITS-1:0] A_NPC   = SPR_ADDR_BITS'(exspr_pkg::IDX_NPC);
  localparam logic [SPR_ADDR_BITS-1:0] A_PPC   = SPR_ADDR_BITS'(exspr_pkg::IDX_PPC);
  localparam logic [SPR_ADDR_BITS-1:0] A_EPCR  = SPR_ADDR_BITS'(exspr_pkg::IDX_EPCR);
  localparam logic [SPR_ADDR_BITS-1:0] A_ESR   = SPR_ADDR_BITS'(exspr_pkg::IDX_ESR);
  localparam int PAD_W = exspr_pkg::OUT_TDATA_W - $bits(exspr_pkg::out_item_t);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_ESR,
    S_FINISH
  } state_t;

  state_t                   state;
  logic [SPR_ADDR_BITS-1:0] clr_cnt;
  logic [31:0]              clr_value;
  logic [31:0]              sr;
  logic                     override;
  logic [31:0]              start_addr;

  exspr_pkg::in_item_t      item;
  exspr_pkg::op_t           op;
  logic [31:0]              esr_value;
  logic [31:0]              res_rd;
  logic [31:0]              res_pc;
  exspr_pkg::status_t       res_st;

  exspr_pkg::in_item_t      s_item;
  exspr_pkg::out_item_t     m_item;

  logic                     mem_we;
  logic [SPR_ADDR_BITS-1:0] mem_waddr;
  logic [31:0]              mem_wdata;
  logic                     mem_re;
  logic [SPR_ADDR_BITS-1:0] mem_raddr;
  logic [31:0]              mem_rdata;

  logic [SPR_ADDR_BITS-1:0] addr;
  logic [15:0]              addr16;
  logic [31:0]              evbar_hi;
  logic [31:0]              vec;
  logic                     vec_out;
  logic                     vec_masked;
  logic [31:0]              exc_pc;
  exspr_pkg::status_t       exc_st;
  logic                     exc_taken;
  logic [31:0]              sr_write;
  logic [31:0]              ttmr_write;
  logic                     out_free;

  assign s_item   = exspr_pkg::in_item_t'(s_tdata[$bits(exspr_pkg::in_item_t)-1:0]);
  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  // store reads happen only at accept, writes only in the later steps and the sweep
  assign mem_re    = s_tvalid && s_tready;
  assign mem_raddr = (exspr_pkg::op_t'(s_tuser) == exspr_pkg::OP_EXCEPT) ?
                     A_EVBAR : s_item.reg_id[SPR_ADDR_BITS-1:0];

  exspr_ram #(
    .ADDR_BITS (SPR_ADDR_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign addr   = item.reg_id[SPR_ADDR_BITS-1:0];
  assign addr16 = 16'(addr);

  // exception filter
  always_comb begin
    evbar_hi   = {12'd0, mem_rdata[31:12]};
    vec        = 32'(exspr_pkg::base_vector(exspr_pkg::cause_t'(item.cause),
                                            item.vector_offset)) + evbar_hi;
    vec_out    = (vec >= exspr_pkg::VEC_LIMIT) ||
                 ((vec & ~exspr_pkg::VEC_MASK) != 32'd0);
    vec_masked = ((vec == 32'(exspr_pkg::VEC_TIMER)) && !override &&
                  !sr[exspr_pkg::SR_TEE]) ||
                 ((vec == 32'(exspr_pkg::VEC_INT)) && !sr[exspr_pkg::SR_IEE]);
    exc_pc     = item.current_pc;
    exc_st     = exspr_pkg::ST_UNHANDLED;
    exc_taken  = 1'b0;
    case (exspr_pkg::cause_t'(item.cause))
      exspr_pkg::CAUSE_ARCH, exspr_pkg::CAUSE_BUS,
      exspr_pkg::CAUSE_INT, exspr_pkg::CAUSE_ILLEGAL: begin
        if (vec_out) begin
          exc_st = exspr_pkg::ST_UNHANDLED;
        end else if (vec_masked) begin
          exc_st = exspr_pkg::ST_MASKED;
        end else begin
          exc_st    = exspr_pkg::ST_ENTERED;
          exc_taken = 1'b1;
          exc_pc    = sr[exspr_pkg::SR_EPH] ? (vec | exspr_pkg::VEC_HIGH) : vec;
        end
      end
      exspr_pkg::CAUSE_ILLJUMP: begin
        exc_st = exspr_pkg::ST_DONE;
        exc_pc = {item.current_pc[31:2], 2'b00};
      end
      exspr_pkg::CAUSE_RSTVEC: begin
        exc_st = exspr_pkg::ST_DONE;
        exc_pc = exspr_pkg::VEC_RESET + evbar_hi;
      end
      default: begin
        exc_st = exspr_pkg::ST_UNHANDLED;
      end
    endcase
  end

  // SR write keeps FO and cannot raise SM from user mode; TTMR write clears IP
  always_comb begin
    sr_write = item.write_value;
    if (!sr[exspr_pkg::SR_SM]) begin
      sr_write[exspr_pkg::SR_SM] = 1'b0;
    end
    sr_write[exspr_pkg::SR_FO] = 1'b1;
    ttmr_write = (addr16 == exspr_pkg::IDX_TTMR) ?
                 (item.write_value & ~exspr_pkg::TTMR_IP) : item.write_value;
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_cnt;
    mem_wdata = 32'd0;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
        mem_wdata = (clr_cnt == A_NPC || clr_cnt == A_PPC) ? clr_value : 32'd0;
      end
      S_LOOKUP: begin
        if (op == exspr_pkg::OP_WRITE && addr16 != exspr_pkg::IDX_SR) begin
          mem_we    = 1'b1;
          mem_waddr = addr;
          mem_wdata = ttmr_write;
        end else if (op == exspr_pkg::OP_EXCEPT && exc_taken) begin
          mem_we    = 1'b1;
          mem_waddr = A_EPCR;
          mem_wdata = item.current_pc;
        end
      end
      S_ESR: begin
        mem_we    = 1'b1;
        mem_waddr = A_ESR;
        mem_wdata = esr_value;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    m_item.read_data  = res_rd;
    m_item.next_pc    = res_pc;
    m_item.pc_changed = (res_pc != item.current_pc);
    m_item.status     = res_st;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_cnt    <= '0;
      clr_value  <= exspr_pkg::START_RESET;
      sr         <= exspr_pkg::SR_RESET;
      override   <= 1'b0;
      start_addr <= exspr_pkg::START_RESET;
      m_tvalid   <= 1'b0;
    end else begin
      if (state == S_FINISH && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          exspr_pkg::CFG_OVERRIDE: override   <= cfg_data[0];
          exspr_pkg::CFG_START:    start_addr <= cfg_data;
          default:                 override   <= override;
        endcase
      end
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == LAST_ADDR) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            item  <= s_item;
            op    <= exspr_pkg::op_t'(s_tuser);
            state <= S_LOOKUP;
          end
        end
        S_LOOKUP: begin
          esr_value <= sr;
          case (op)
            exspr_pkg::OP_READ: begin
              res_rd <= (addr16 == exspr_pkg::IDX_SR) ? sr : mem_rdata;
              res_pc <= item.current_pc;
              res_st <= exspr_pkg::ST_DONE;
              state  <= S_FINISH;
            end
            exspr_pkg::OP_WRITE: begin
              res_rd <= 32'd0;
              res_pc <= item.current_pc;
              res_st <= exspr_pkg::ST_DONE;
              state  <= S_FINISH;
              if (addr16 == exspr_pkg::IDX_SR) begin
                sr <= sr_write;
              end
            end
            exspr_pkg::OP_EXCEPT: begin
              res_rd <= 32'd0;
              res_pc <= exc_pc;
              res_st <= exc_st;
              state  <= exc_taken ? S_ESR : S_FINISH;
              if (exc_taken) begin
                sr <= (sr & ~exspr_pkg::SR_ENTRY_CLR) | 32'd1 << exspr_pkg::SR_SM;
              end
            end
            exspr_pkg::OP_RESET: begin
              res_rd    <= 32'd0;
              res_pc    <= start_addr;
              res_st    <= exspr_pkg::ST_DONE;
              state     <= S_FINISH;
              sr        <= exspr_pkg::SR_RESET;
              clr_value <= start_addr;
            end
            default: begin
              res_rd <= 32'd0;
              res_pc <= item.current_pc;
              res_st <= exspr_pkg::ST_DONE;
              state  <= S_FINISH;
            end
          endcase
        end
        S_ESR: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            m_tdata  <= {{PAD_W{1'b0}}, m_item};
            if (op == exspr_pkg::OP_RESET) begin
              clr_cnt <= '0;
              state   <= S_CLEAR;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // the lookup step always follows an accepted request
  a_lookup_after_accept: assert property (@(posedge clk) disable iff (rst)
    state == S_LOOKUP |-> $past(s_tvalid && s_tready))
    else $error("lookup without an accepted request");

  // read and write of the store never share a cycle
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |-> !mem_we)
    else $error("store read and write in the same cycle");

  // the fixed-one bit of SR never drops
  a_sr_fo: assert property (@(posedge clk) disable iff (rst)
    sr[exspr_pkg::SR_FO])
    else $error("SR fixed-one bit cleared");

  // ESR write only right after a taken exception, in supervisor mode
  a_esr_entry: assert property (@(posedge clk) disable iff (rst)
    state == S_ESR |-> $past(state == S_LOOKUP) && sr[exspr_pkg::SR_SM] &&
                       res_st == exspr_pkg::ST_ENTERED)
    else $error("ESR write outside exception entry");

endmodule

@@ verif/exception_entry_and_spr_unit_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exception_entry_and_spr_unit_top_tb
// Drives register reads, register writes, exception events and core resets
// into the unit and checks every result against an in-bench predictor of the
// register store, status word and exception filter, or for directed rows with
// chk set against the row's values. A directed table runs first; three random
// phases follow, each with its own configuration and sender/receiver idling.
// ----------------------------------------------------------------------------
module exception_entry_and_spr_unit_top_tb;

  localparam int          ADDR_BITS     = 16;
  localparam int          PHASE_REQS    = 500;
  localparam int          RESET_AT      = 10;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          TIMEOUT_NS    = 4_000_000;
  localparam logic [2:0]  CAUSE_UNDEF   = 3'd7;
  localparam int          IN_PAD_W      =
    exspr_pkg::IN_TDATA_W - $bits(exspr_pkg::in_item_t);

  typedef struct packed {
    exspr_pkg::op_t     op;
    logic [15:0]        reg_id;
    logic [31:0]        wdata;
    logic [2:0]         cause;
    logic [15:0]        offset;
    logic [31:0]        pc;
    logic               chk;
    logic [31:0]        rd;
    logic [31:0]        npc;
    exspr_pkg::status_t st;
  } dir_row_t;

  // rows with chk set carry their expected read_data, next_pc and status
  localparam dir_row_t DIRECTED [27] = '{
    '{exspr_pkg::OP_READ, exspr_pkg::IDX_SR, 32'h0, exspr_pkg::CAUSE_ARCH, 16'h0,
      32'h0,
      1'b1, exspr_pkg::SR_RESET, 32'h0, exspr_pkg::ST_DONE},
    '{exspr_pkg::OP_READ, exspr_pkg::IDX_NPC, 32'h0, exspr_pkg::CAUSE_ARCH, 16'h0,
      exspr_pkg::START_RESET,
      1'b1, exspr_pkg::START_RESET, exspr_pkg::START_RESET, exspr_pkg::ST_DONE},
    '{exspr_pkg::OP_READ, exspr_pkg::IDX_PPC, 32'h0, exspr_pkg::CAUSE_ARCH, 16'h0,
      32'hFFFF_FFFF,
      1'b1, exspr_pkg::START_RESET, 32'hFFFF_FFFF, exspr_pkg::ST_DONE},
    '{exspr_pkg::OP_WRITE, 16'hFFFF, 32'hFFFF_FFFF, exspr_pkg::CAUSE_ARCH, 16'h0,
      32'h0,
      1'b1, 32'h0, 32'h0, exspr_pkg::ST_DONE},
    '{exspr_pkg::OP_READ, 16'hFFFF, 32'h0, exspr_pkg::CAUSE_ARCH, 16'h0,
      32'h0,
      1'b0, 32'h0, 32'h0, exspr_pkg::ST_DONE},
    '{exspr_pkg::OP_WRITE, exspr_pkg::IDX_TTMR, 32'hFFFF_FFFF, exspr_pkg::CAUSE_ARCH,
      16'h0, 32'h10,
      1'b1, 32'h0, 32'h10, exspr_pkg::ST_DONE},
    '{exspr_pkg::OP_READ, exspr_pkg::IDX_TTMR, 32'h0, exspr_pkg::CAUSE_ARCH, 16'h0,
      32'h10,
      1'b0, 32'h0, 32'h0, exspr_pkg::ST_DONE},
    '{exspr_pkg::OP_EXCEPT, 16'h0, 32'h0, exspr_pkg::CAUSE_ARCH, exspr_pkg::VEC_TIMER,
      32'h2000,
      1'b1, 32'h0, 32'h2000, exspr_pkg::ST_MASKED},
    '{exspr_pkg::OP_EXCEPT, 16'h0, 32'h0, exspr_pkg::CAUSE_INT, 16'h0,
      32'h2004,
      1'b1, 32'h0, 32'h2004, exspr_pkg::ST_MASKED},
    '{exspr_pkg::OP_EXCEPT, 16'h0, 32'h0, exspr_pkg::CAUSE_FOREIGN, 16'h0,
      32'h2008,
      1'b1, 32'h0, 32'h2008, exspr_pkg::ST_UNHANDLED},
    '{exspr_pkg::OP_EXCEPT, 16'h0, 32'h0, CAUSE_UNDEF, 16'hFFFF,
      32'h200C,
      1'b1, 32'h0, 32'h200C, exspr_pkg::ST_UNHANDLED},
    '{exspr_pkg::OP_EXCEPT, 16'h0, 32'h0, exspr_pkg::CAUSE_ARCH, 16'h0F00,
      32'h2010,
      1'b1, 32'h0, 32'h2010, exspr_pkg::ST_UNHANDLED},
    '{exspr_pkg::OP_EXCEPT, 16'h0, 32'h0, exspr_pkg::CAUSE_ARCH, 16'h0123,
      32'h2014,
      1'b1, 32'h0, 32'h2014, exspr_pkg::ST_UNHANDLED},
    '{exspr_pkg::OP_EXCEPT, 16'h0, 32'h0, exspr_pkg::CAUSE_ILLJUMP, 16'h0,
      32'hFFFF_FFFF,
      1'b1, 32'h0, 32'hFFFF_FFFC, exspr_pkg::ST_DONE},
    '{exspr_pkg::OP_EXCEPT, 16'h0, 32'h0, exspr_pkg::CAUSE_RSTVEC, 16'h0,
      32'h0,
      1'b1, 32'h0, exspr_pkg::VEC_RESET, exspr_pkg::ST_DONE},
    '{exspr_pkg::OP_EXCEPT, 16'h0, 32'h0, exspr_pkg::CAUSE_BUS, 16'h0,
      32'h3000,
      1'b0, 32'h0, 32'h0, exspr_pkg::ST_DONE},
    '{exspr_pkg::OP_READ, exspr_pkg::IDX_EPCR, 32'h0, exspr_pkg::CAUSE_ARCH, 16'h0,
      32'h3000,
      1'b0, 32'h0, 32'h0, exspr_pkg::ST_DONE},
    '{exspr_pkg::OP_WRITE, exspr_pkg::IDX_SR, 32'h0000_4006, exspr_pkg::CAUSE_ARCH,
      16'h0, 32'h3000,
      1'b0, 32'h0, 32'h0, exspr_pkg::ST_DONE},
    '{exspr_pkg::OP_EXCEPT, 16'h0, 32'h0, exspr_pkg::CAUSE_ARCH, exspr_pkg::VEC_TIMER,
      32'h4000,
      1'b0, 32'h0, 32'h0, exspr_pkg::ST_DONE},
    '{exspr_pkg::OP_WRITE, exspr_pkg::IDX_SR, 32'h0000_4004, exspr_pkg::CAUSE_ARCH,
      16'h0, 32'h4000,
      1'b0, 32'h0, 32'h0, exspr_pkg::ST_DONE},
    '{exspr_pkg::OP_WRITE, exspr_pkg::IDX_SR, 32'hFFFF_FFFF, exspr_pkg::CAUSE_ARCH,
      16'h0, 32'h4000,
      1'b0, 32'h0, 32'h0, exspr_pkg::ST_DONE},
    '{exspr_pkg::OP_EXCEPT, 16'h0, 32'h0, exspr_pkg::CAUSE_INT, 16'h0,
      32'h0,
      1'b0, 32'h0, 32'h0, exspr_pkg::ST_DONE},
    '{exspr_pkg::OP_EXCEPT, 16'h0, 32'h0, exspr_pkg::CAUSE_ARCH, 16'h0,
      exspr_pkg::VEC_HIGH,
      1'b0, 32'h0, 32'h0, exspr_pkg::ST_DONE},
    '{exspr_pkg::OP_WRITE, exspr_pkg::IDX_EVBAR, 32'h0020_0000, exspr_pkg::CAUSE_ARCH,
      16'h0, 32'h0,
      1'b0, 32'h0, 32'h0, exspr_pkg::ST_DONE},
    '{exspr_pkg::OP_EXCEPT, 16'h0, 32'h0, exspr_pkg::CAUSE_ILLEGAL, 16'h0,
      32'h5000,
      1'b0, 32'h0, 32'h0, exspr_pkg::ST_DONE},
    '{exspr_pkg::OP_RESET, 16'h0, 32'h0, exspr_pkg::CAUSE_ARCH, 16'h0,
      32'h0,
      1'b1, 32'h0, exspr_pkg::START_RESET, exspr_pkg::ST_DONE},
    '{exspr_pkg::OP_READ, exspr_pkg::IDX_EVBAR, 32'h0, exspr_pkg::CAUSE_ARCH, 16'h0,
      32'h0,
      1'b1, 32'h0, 32'h0, exspr_pkg::ST_DONE}
  };

  logic                              clk;
  logic                              rst;
  logic                              s_tvalid;
  logic                              s_tready;
  logic [exspr_pkg::IN_TDATA_W-1:0]  s_tdata;
  logic [1:0]                        s_tuser;
  logic                              m_tvalid;
  logic                              m_tready;
  logic [exspr_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic                              cfg_we;
  logic                              cfg_index;
  logic [31:0]                       cfg_data;

  // predicted unit state
  bit   [31:0]           spr_words [2**ADDR_BITS];
  logic [31:0]           sr_word;
  logic                  override_on;
  logic [31:0]           boot_pc;
  exspr_pkg::out_item_t  pending_results [$];

  // typed expectation that travels with the request on the bus
  logic                  row_check;
  exspr_pkg::out_item_t  row_result;

  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  bit          hold_req = 1'b0;
  int unsigned err_count = 0;
  int unsigned op_count [4];
  int unsigned status_count [4];

  exception_entry_and_spr_unit_top #(
    .SPR_ADDR_BITS(ADDR_BITS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("*** FAILED ***");
    $finish;
  end

  function automatic void clear_store();
    foreach (spr_words[i]) spr_words[i] = '0;
    sr_word = exspr_pkg::SR_RESET;
    spr_words[exspr_pkg::IDX_NPC] = boot_pc;
    spr_words[exspr_pkg::IDX_PPC] = boot_pc;
  endfunction

  function automatic exspr_pkg::out_item_t predict_result(input exspr_pkg::op_t op,
                                                          input exspr_pkg::in_item_t req);
    exspr_pkg::out_item_t res;
    logic [ADDR_BITS-1:0] addr;
    logic [31:0]          val;
    logic [31:0]          vec;
    logic [31:0]          pc;
    logic [31:0]          base_shift;
    addr = req.reg_id[ADDR_BITS-1:0];
    pc = req.current_pc;
    vec = '0;
    base_shift = spr_words[exspr_pkg::IDX_EVBAR] >> 12;
    res.read_data = '0;
    res.status = exspr_pkg::ST_DONE;
    case (op)
      exspr_pkg::OP_READ: begin
        res.read_data = (addr == exspr_pkg::IDX_SR) ? sr_word : spr_words[addr];
      end
      exspr_pkg::OP_WRITE: begin
        val = req.write_value;
        if (addr == exspr_pkg::IDX_SR) begin
          // no way back to supervisor mode from user mode by a write
          if (!sr_word[exspr_pkg::SR_SM]) val[exspr_pkg::SR_SM] = 1'b0;
          val[exspr_pkg::SR_FO] = 1'b1;
          sr_word = val;
        end else begin
          if (addr == exspr_pkg::IDX_TTMR) val = val & ~exspr_pkg::TTMR_IP;
          spr_words[addr] = val;
        end
      end
      exspr_pkg::OP_EXCEPT: begin
        case (req.cause)
          exspr_pkg::CAUSE_ARCH:    vec[15:0] = req.vector_offset;
          exspr_pkg::CAUSE_BUS:     vec[15:0] = exspr_pkg::VEC_BUS;
          exspr_pkg::CAUSE_INT:     vec[15:0] = exspr_pkg::VEC_INT;
          exspr_pkg::CAUSE_ILLEGAL: vec[15:0] = exspr_pkg::VEC_ILLEGAL;
          exspr_pkg::CAUSE_ILLJUMP: pc[1:0] = 2'b00;
          exspr_pkg::CAUSE_RSTVEC:  pc = exspr_pkg::VEC_RESET + base_shift;
          default:                  res.status = exspr_pkg::ST_UNHANDLED;
        endcase
        if (req.cause <= exspr_pkg::CAUSE_ILLEGAL) begin
          vec = vec + base_shift;
          if (vec >= exspr_pkg::VEC_LIMIT || (vec & exspr_pkg::VEC_MASK) != vec) begin
            res.status = exspr_pkg::ST_UNHANDLED;
          end else if ((vec == exspr_pkg::VEC_TIMER && !override_on &&
                        !sr_word[exspr_pkg::SR_TEE]) ||
                       (vec == exspr_pkg::VEC_INT && !sr_word[exspr_pkg::SR_IEE])) begin
            res.status = exspr_pkg::ST_MASKED;
          end else begin
            if (sr_word[exspr_pkg::SR_EPH]) vec = vec | exspr_pkg::VEC_HIGH;
            spr_words[exspr_pkg::IDX_EPCR] = req.current_pc;
            spr_words[exspr_pkg::IDX_ESR] = sr_word;
            sr_word = sr_word & ~exspr_pkg::SR_ENTRY_CLR;
            sr_word[exspr_pkg::SR_SM] = 1'b1;
            pc = vec;
            res.status = exspr_pkg::ST_ENTERED;
          end
        end
      end
      default: begin
        clear_store();
        pc = boot_pc;
      end
    endcase
    res.next_pc = pc;
    res.pc_changed = (pc != req.current_pc);
    return res;
  endfunction

  // predict on every accepted request, check every accepted result
  always @(posedge clk) begin
    exspr_pkg::in_item_t  req;
    exspr_pkg::out_item_t exp_res;
    exspr_pkg::out_item_t got;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        req = s_tdata[$bits(exspr_pkg::in_item_t)-1:0];
        exp_res = predict_result(exspr_pkg::op_t'(s_tuser), req);
        if (row_check) exp_res = row_result;
        pending_results = {pending_results, exp_res};
        op_count[s_tuser]++;
      end
      if (m_tvalid && m_tready) begin
        got = m_tdata[$bits(exspr_pkg::out_item_t)-1:0];
        if (pending_results.size() == 0) begin
          $error("result with nothing expected: %h", got);
          err_count++;
        end else begin
          exp_res = pending_results.pop_front();
          if (got.read_data !== exp_res.read_data) begin
            $error("read_data: expected %h, got %h", exp_res.read_data, got.read_data);
            err_count++;
          end
          if (got.next_pc !== exp_res.next_pc) begin
            $error("next_pc: expected %h, got %h", exp_res.next_pc, got.next_pc);
            err_count++;
          end
          if (got.pc_changed !== exp_res.pc_changed) begin
            $error("pc_changed: expected %b, got %b", exp_res.pc_changed, got.pc_changed);
            err_count++;
          end
          if (got.status !== exp_res.status) begin
            $error("status: expected %0d, got %0d", exp_res.status, got.status);
            err_count++;
          end
          status_count[got.status]++;
        end
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic send_req(input exspr_pkg::op_t op, input exspr_pkg::in_item_t req,
                          input logic chk, input exspr_pkg::out_item_t res);
    if ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    s_tvalid   <= 1'b1;
    s_tuser    <= op;
    s_tdata    <= {{IN_PAD_W{1'b0}}, req};
    row_check  <= chk;
    row_result <= res;
    do @(posedge clk); while (!s_tready);
  endtask

  // drop valid, drain all results, then let a late store sweep finish
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic set_config(input logic ovr, input logic [31:0] start);
    cfg_we    <= 1'b1;
    cfg_index <= exspr_pkg::CFG_OVERRIDE;
    cfg_data  <= {31'b0, ovr};
    @(posedge clk);
    override_on = ovr;
    cfg_index <= exspr_pkg::CFG_START;
    cfg_data  <= start;
    @(posedge clk);
    boot_pc = start;
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] pick_reg();
    case ($urandom_range(9))
      0: return exspr_pkg::IDX_EVBAR;
      1: return exspr_pkg::IDX_SR;
      2: return $urandom_range(1) ? exspr_pkg::IDX_NPC : exspr_pkg::IDX_PPC;
      3: return $urandom_range(1) ? exspr_pkg::IDX_EPCR : exspr_pkg::IDX_ESR;
      4: return exspr_pkg::IDX_TTMR;
      5, 6: return 16'($urandom_range(127));
      7: return 16'hFFF0 | 16'($urandom_range(15));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic void random_req(output exspr_pkg::op_t op,
                                     output exspr_pkg::in_item_t req);
    int unsigned dice;
    req.reg_id = pick_reg();
    req.write_value = $urandom;
    // keep EVBAR mostly on vector-aligned bases so exceptions pass the range check
    if (req.reg_id == exspr_pkg::IDX_EVBAR && $urandom_range(3) != 0)
      req.write_value = (32'($urandom_range(7)) << 20) | (req.write_value & 32'hFFF);
    req.current_pc = $urandom;
    case ($urandom_range(11))
      0, 1, 2, 3: req.cause = exspr_pkg::CAUSE_ARCH;
      4:          req.cause = exspr_pkg::CAUSE_BUS;
      5, 11:      req.cause = exspr_pkg::CAUSE_INT;
      6:          req.cause = exspr_pkg::CAUSE_ILLEGAL;
      7:          req.cause = exspr_pkg::CAUSE_ILLJUMP;
      8:          req.cause = exspr_pkg::CAUSE_RSTVEC;
      9:          req.cause = exspr_pkg::CAUSE_FOREIGN;
      default:    req.cause = CAUSE_UNDEF;
    endcase
    case ($urandom_range(4))
      0:       req.vector_offset = exspr_pkg::VEC_TIMER;
      1:       req.vector_offset = exspr_pkg::VEC_INT;
      2, 3:    req.vector_offset = 16'($urandom_range(15)) << 8;
      default: req.vector_offset = 16'($urandom);
    endcase
    dice = $urandom_range(99);
    op = (dice < 30) ? exspr_pkg::OP_READ :
         (dice < 60) ? exspr_pkg::OP_WRITE : exspr_pkg::OP_EXCEPT;
  endfunction

  task automatic run_phase(input logic ovr, input logic [31:0] start, input int tx_pct,
                           input int rx_pct, input int pause_at, input int hold_at);
    exspr_pkg::op_t      op;
    exspr_pkg::in_item_t req;
    settle();
    set_config(ovr, start);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int n = 0; n < PHASE_REQS; n++) begin
      if (n == pause_at) begin
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
      end
      if (n == hold_at) hold_req = 1'b1;
      random_req(op, req);
      if (n == RESET_AT) op = exspr_pkg::OP_RESET;
      send_req(op, req, 1'b0, '0);
    end
  endtask

  initial begin
    exspr_pkg::in_item_t  req;
    exspr_pkg::out_item_t res;
    rst        <= 1'b1;
    s_tvalid   <= 1'b0;
    s_tuser    <= exspr_pkg::OP_READ;
    s_tdata    <= '0;
    row_check  <= 1'b0;
    row_result <= '0;
    cfg_we     <= 1'b0;
    cfg_index  <= exspr_pkg::CFG_OVERRIDE;
    cfg_data   <= '0;
    override_on = 1'b0;
    boot_pc = exspr_pkg::START_RESET;
    clear_store();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i]) begin
      req.reg_id        = DIRECTED[i].reg_id;
      req.write_value   = DIRECTED[i].wdata;
      req.cause         = DIRECTED[i].cause;
      req.vector_offset = DIRECTED[i].offset;
      req.current_pc    = DIRECTED[i].pc;
      res.read_data     = DIRECTED[i].rd;
      res.next_pc       = DIRECTED[i].npc;
      res.pc_changed    = (DIRECTED[i].npc != DIRECTED[i].pc);
      res.status        = DIRECTED[i].st;
      send_req(DIRECTED[i].op, req, DIRECTED[i].chk, res);
    end

    run_phase(1'b1, 32'h0000_0000, 29, 52, 250, -1);
    run_phase(1'b0, 32'hFFFF_FFFF, 52, 29, -1, 100);
    run_phase(1'($urandom_range(1)), $urandom, 0, 0, 300, 50);
    settle();

    $display("requests: %0d reads, %0d writes, %0d exception events, %0d core resets",
             op_count[exspr_pkg::OP_READ], op_count[exspr_pkg::OP_WRITE],
             op_count[exspr_pkg::OP_EXCEPT], op_count[exspr_pkg::OP_RESET]);
    $display("results: %0d done, %0d entered, %0d masked, %0d handed back; %0d errors",
             status_count[exspr_pkg::ST_DONE], status_count[exspr_pkg::ST_ENTERED],
             status_count[exspr_pkg::ST_MASKED], status_count[exspr_pkg::ST_UNHANDLED],
             err_count);
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
